FILE: design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LTA_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LTA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lta_pkg.sv
package lta_pkg;

  // field and datapath widths
  localparam int MAG_W  = 40;   // |x| of a 40-bit signed value
  localparam int WS_W   = 41;   // normalized direction component
  localparam int SQ_W   = 82;   // sum of squared position magnitudes
  localparam int D_W    = 89;   // 100 * sum of squares, clamped
  localparam int DEN_W  = 122;  // clamped distance term times mass
  localparam int NUM_W  = 113;  // thrust * 1e6 * au^2
  localparam int TM_W   = 52;   // thrust * 1e6
  localparam int QA_W   = 59;   // magnitude quotient
  localparam int WSUM_W = 84;   // sum of squared direction components
  localparam int TR_W   = 85;   // square root trial value
  localparam int N_W    = 42;   // direction norm
  localparam int PROD_W = 100;  // magnitude times component
  localparam int QF_W   = 48;   // per-axis quotient
  localparam int ACC_W  = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [19:0] MICRO_PER_UNIT = 20'd1000000;
  localparam logic [63:0] AU_DKM    = 64'd1495978707;
  localparam logic [63:0] AU2       = AU_DKM * AU_DKM;
  localparam logic [63:0] AU2_FLOOR = AU2 / 64'd100;
  localparam int          AU2_W     = 61;

  localparam logic [ACC_W-1:0] ACC_POS_LIM = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_LIM = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_Z  = 3'd5;

  // pointing modes
  localparam logic [2:0] MODE_PROGRADE  = 3'd0;
  localparam logic [2:0] MODE_RETRO     = 3'd1;
  localparam logic [2:0] MODE_SUN       = 3'd2;
  localparam logic [2:0] MODE_ANTISUN   = 3'd3;
  localparam logic [2:0] MODE_FIXED     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMASS  = 2'd1,
    ST_ZERODIR = 2'd2,
    ST_CUSTOM  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [39:0] vel_z;
    logic        [31:0] mass_grams;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic        [1:0]       thrust_status;
  } out_item_t;

  // magnitude divider and square root stage
  typedef struct packed {
    logic [NUM_W-1:0]           rem;
    logic [DEN_W-1:0]           den;
    logic [QA_W-1:0]            q;
    logic [WSUM_W-1:0]          srem;
    logic [N_W-1:0]             root;
    logic [2:0][WS_W-1:0]       ws;
    logic [2:0]                 neg;
    status_t                    st;
  } dv_t;

  // per-axis divider stage
  typedef struct packed {
    logic [2:0][PROD_W-1:0] rem;
    logic [2:0][QF_W-1:0]   q;
    logic [2:0]             ovf;
    logic [N_W-1:0]         n;
    logic [2:0]             neg;
    status_t                st;
  } fq_t;

endpackage

FILE: design/low_thrust_acceleration_core.sv
// Thrust acceleration of a solar electric spacecraft. Each input item carries a
// heliocentric position (km), a velocity (mm/s) and a mass (g); each produces
// exactly one result item with the acceleration vector in nm/s^2, saturated to
// 48 bits, and a status (0 thrusting, 1 no mass, 2 zero direction, 3 custom
// mode; on a nonzero status the vector is zero). Thrust magnitude is
// thrust * 1e6 / mass, optionally scaled by au^2 / max(r^2, (0.1 au)^2), and
// is pointed along or against the normalized velocity or position, or along
// the fixed vector, as the pointing mode register selects. The block is a
// 118-stage pipeline that accepts one item per clock while in_stall is low.
// The depth comes from the restoring divider for the magnitude (one quotient
// bit per stage, 59 stages, with the norm square root riding in the first 42
// of them) and the per-axis divider (48 quotient-bit stages). A one-entry skid
// register behind the last stage absorbs an output stall, so in_stall is a
// plain register and rises only when that entry is full; then the whole
// pipeline holds. Registers are written through the cfg port, always ready,
// and must be written only while no item is in flight.
module low_thrust_acceleration_core
  import lta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0]      thr_r;
  logic             scale_r;
  logic [2:0]       mode_r;
  logic [2:0][31:0] fix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      scale_r <= 1'b0;
      mode_r  <= '0;
      fix_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRUST: thr_r    <= cfg_data;
        CFG_SCALE:  scale_r  <= cfg_data[0];
        CFG_MODE:   mode_r   <= cfg_data[2:0];
        CFG_FIX_X:  fix_r[0] <= cfg_data;
        CFG_FIX_Y:  fix_r[1] <= cfg_data;
        CFG_FIX_Z:  fix_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; it holds only while the skid entry is full
  logic skid_full_r;
  logic adv;
  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;

  function automatic logic [MAG_W-1:0] mag40(input logic [MAG_W-1:0] v);
    mag40 = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  // ---------------------------------------------------------------------------
  // s1: early status, pointing vector select, magnitudes, thrust * 1e6
  // ---------------------------------------------------------------------------
  logic                  s1_vld_r;
  status_t               s1_st_r, s1_st_nxt;
  logic [2:0][MAG_W-1:0] s1_wmag_r, s1_wmag_nxt;
  logic [2:0]            s1_neg_r, s1_neg_nxt;
  logic [2:0][MAG_W-1:0] s1_pmag_r, s1_pmag_nxt;
  logic [TM_W-1:0]       s1_tm_r, s1_tm_nxt;
  logic [31:0]           s1_mass_r;

  logic [2:0][MAG_W-1:0] pv, vv, fv, wsel;
  logic                  flip;

  assign pv = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign vv = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

  always_comb begin
    s1_st_nxt = ST_OK;
    if (in_data.mass_grams == '0) begin
      s1_st_nxt = ST_NOMASS;
    end else if (mode_r > MODE_FIXED) begin
      s1_st_nxt = ST_CUSTOM;
    end
    flip = (mode_r == MODE_RETRO) || (mode_r == MODE_ANTISUN);
    for (int i = 0; i < 3; i++) begin
      fv[i] = {{(MAG_W-32){fix_r[i][31]}}, fix_r[i]};
    end
    case (mode_r)
      MODE_PROGRADE, MODE_RETRO: wsel = vv;
      MODE_SUN, MODE_ANTISUN:    wsel = pv;
      default:                   wsel = fv;
    endcase
    for (int i = 0; i < 3; i++) begin
      s1_wmag_nxt[i] = mag40(wsel[i]);
      s1_neg_nxt[i]  = wsel[i][MAG_W-1] ^ flip;
      s1_pmag_nxt[i] = mag40(pv[i]);
    end
    s1_tm_nxt = TM_W'(thr_r) * TM_W'(MICRO_PER_UNIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_st_r   <= s1_st_nxt;
      s1_wmag_r <= s1_wmag_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_pmag_r <= s1_pmag_nxt;
      s1_tm_r   <= s1_tm_nxt;
      s1_mass_r <= in_data.mass_grams;
    end
  end

  // ---------------------------------------------------------------------------
  // s2: partial squares of position, partial products of thrust * au^2,
  //     largest direction component
  // ---------------------------------------------------------------------------
  logic                  s2_vld_r;
  status_t               s2_st_r;
  logic [2:0][MAG_W-1:0] s2_wmag_r;
  logic [2:0]            s2_neg_r;
  logic [MAG_W-1:0]      s2_big_r, s2_big_nxt;
  logic [2:0][59:0]      s2_pplo_r, s2_pplo_nxt, s2_pphi_r, s2_pphi_nxt;
  logic [86:0]           s2_nl_r, s2_nh_r;
  logic [TM_W-1:0]       s2_tm_r;
  logic [31:0]           s2_mass_r;

  always_comb begin
    s2_big_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_wmag_r[i] > s2_big_nxt) begin
        s2_big_nxt = s1_wmag_r[i];
      end
      s2_pplo_nxt[i] = 60'(s1_pmag_r[i]) * 60'(s1_pmag_r[i][19:0]);
      s2_pphi_nxt[i] = 60'(s1_pmag_r[i]) * 60'(s1_pmag_r[i][39:20]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_st_r   <= s1_st_r;
      s2_wmag_r <= s1_wmag_r;
      s2_neg_r  <= s1_neg_r;
      s2_big_r  <= s2_big_nxt;
      s2_pplo_r <= s2_pplo_nxt;
      s2_pphi_r <= s2_pphi_nxt;
      s2_nl_r   <= 87'(s1_tm_r[25:0]) * 87'(AU2[AU2_W-1:0]);
      s2_nh_r   <= 87'(s1_tm_r[TM_W-1:26]) * 87'(AU2[AU2_W-1:0]);
      s2_tm_r   <= s1_tm_r;
      s2_mass_r <= s1_mass_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s3: sum of squares, full numerator, normalizing shift count
  // ---------------------------------------------------------------------------
  logic                  s3_vld_r;
  status_t               s3_st_r, s3_st_nxt;
  logic [2:0][MAG_W-1:0] s3_wmag_r;
  logic [2:0]            s3_neg_r;
  logic [5:0]            s3_sh_r, s3_sh_nxt;
  logic [5:0]            msb;
  logic [SQ_W-1:0]       s3_sq_r, s3_sq_nxt;
  logic [NUM_W-1:0]      s3_num_r;
  logic [TM_W-1:0]       s3_tm_r;
  logic [31:0]           s3_mass_r;

  always_comb begin
    s3_st_nxt = s2_st_r;
    if (s2_st_r == ST_OK && s2_big_r == '0) begin
      s3_st_nxt = ST_ZERODIR;
    end
    // shift that lands the largest component in [2^40, 2^41)
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (s2_big_r[b]) begin
        msb = 6'(b);
      end
    end
    s3_sh_nxt = 6'(MAG_W) - msb;
    s3_sq_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s3_sq_nxt = s3_sq_nxt + SQ_W'(s2_pplo_r[i]) + (SQ_W'(s2_pphi_r[i]) << 20);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_st_r   <= s3_st_nxt;
      s3_wmag_r <= s2_wmag_r;
      s3_neg_r  <= s2_neg_r;
      s3_sh_r   <= s3_sh_nxt;
      s3_sq_r   <= s3_sq_nxt;
      s3_num_r  <= NUM_W'(s2_nl_r) + (NUM_W'(s2_nh_r) << 26);
      s3_tm_r   <= s2_tm_r;
      s3_mass_r <= s2_mass_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s4: 100 * r^2 with the 0.1 au clamp, direction normalized by shift
  // ---------------------------------------------------------------------------
  logic                 s4_vld_r;
  status_t              s4_st_r;
  logic [2:0]           s4_neg_r;
  logic [2:0][WS_W-1:0] s4_ws_r, s4_ws_nxt;
  logic [D_W-1:0]       s4_dc_r, s4_dc_nxt, d100;
  logic [NUM_W-1:0]     s4_num_r;
  logic [TM_W-1:0]      s4_tm_r;
  logic [31:0]          s4_mass_r;

  always_comb begin
    d100 = D_W'(s3_sq_r) * D_W'(7'd100);
    s4_dc_nxt = (d100 < D_W'(AU2_FLOOR)) ? D_W'(AU2_FLOOR) : d100;
    for (int i = 0; i < 3; i++) begin
      s4_ws_nxt[i] = WS_W'(s3_wmag_r[i]) << s3_sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_st_r   <= s3_st_r;
      s4_neg_r  <= s3_neg_r;
      s4_ws_r   <= s4_ws_nxt;
      s4_dc_r   <= s4_dc_nxt;
      s4_num_r  <= s3_num_r;
      s4_tm_r   <= s3_tm_r;
      s4_mass_r <= s3_mass_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s5: partial products of distance term * mass and of squared direction
  // ---------------------------------------------------------------------------
  logic                 s5_vld_r;
  status_t              s5_st_r;
  logic [2:0]           s5_neg_r;
  logic [2:0][WS_W-1:0] s5_ws_r;
  logic [2:0][61:0]     s5_dp_r, s5_dp_nxt, s5_wlo_r, s5_wlo_nxt, s5_whi_r, s5_whi_nxt;
  logic [NUM_W-1:0]     s5_num_r;
  logic [TM_W-1:0]      s5_tm_r;
  logic [31:0]          s5_mass_r;

  always_comb begin
    s5_dp_nxt[0] = 62'(s4_dc_r[29:0])  * 62'(s4_mass_r);
    s5_dp_nxt[1] = 62'(s4_dc_r[59:30]) * 62'(s4_mass_r);
    s5_dp_nxt[2] = 62'(s4_dc_r[88:60]) * 62'(s4_mass_r);
    for (int i = 0; i < 3; i++) begin
      s5_wlo_nxt[i] = 62'(s4_ws_r[i]) * 62'(s4_ws_r[i][20:0]);
      s5_whi_nxt[i] = 62'(s4_ws_r[i]) * 62'(s4_ws_r[i][40:21]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_st_r   <= s4_st_r;
      s5_neg_r  <= s4_neg_r;
      s5_ws_r   <= s4_ws_r;
      s5_dp_r   <= s5_dp_nxt;
      s5_wlo_r  <= s5_wlo_nxt;
      s5_whi_r  <= s5_whi_nxt;
      s5_num_r  <= s4_num_r;
      s5_tm_r   <= s4_tm_r;
      s5_mass_r <= s4_mass_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s6: divider operands chosen by solar scaling, per-axis squares summed
  // ---------------------------------------------------------------------------
  logic                 s6_vld_r;
  status_t              s6_st_r;
  logic [2:0]           s6_neg_r;
  logic [2:0][WS_W-1:0] s6_ws_r;
  logic [2:0][82:0]     s6_wsq_r, s6_wsq_nxt;
  logic [DEN_W-1:0]     s6_den_r, s6_den_nxt;
  logic [NUM_W-1:0]     s6_num_r, s6_num_nxt;

  always_comb begin
    if (scale_r) begin
      s6_den_nxt = DEN_W'(s5_dp_r[0]) + (DEN_W'(s5_dp_r[1]) << 30)
                 + (DEN_W'(s5_dp_r[2]) << 60);
      s6_num_nxt = s5_num_r;
    end else begin
      s6_den_nxt = DEN_W'(s5_mass_r);
      s6_num_nxt = NUM_W'(s5_tm_r);
    end
    for (int i = 0; i < 3; i++) begin
      s6_wsq_nxt[i] = 83'(s5_wlo_r[i]) + (83'(s5_whi_r[i]) << 21);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_st_r  <= s5_st_r;
      s6_neg_r <= s5_neg_r;
      s6_ws_r  <= s5_ws_r;
      s6_wsq_r <= s6_wsq_nxt;
      s6_den_r <= s6_den_nxt;
      s6_num_r <= s6_num_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // magnitude divider, one quotient bit per stage; the norm square root
  // resolves one root bit per stage in the first N_W of them
  // ---------------------------------------------------------------------------
  dv_t              dv_r [0:QA_W];
  logic [QA_W:0]    dv_vld_r;
  dv_t              dv0_nxt;

  always_comb begin
    dv0_nxt      = '0;
    dv0_nxt.rem  = s6_num_r;
    dv0_nxt.den  = s6_den_r;
    dv0_nxt.srem = WSUM_W'(s6_wsq_r[0]) + WSUM_W'(s6_wsq_r[1]) + WSUM_W'(s6_wsq_r[2]);
    dv0_nxt.ws   = s6_ws_r;
    dv0_nxt.neg  = s6_neg_r;
    dv0_nxt.st   = s6_st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else if (adv) begin
      dv_vld_r <= {dv_vld_r[QA_W-1:0], s6_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 0; k < QA_W; k++) begin : g_div
    localparam int QB = QA_W - 1 - k;
    dv_t              dnx, snx;
    logic [DEN_W-1:0] rx, hi;

    always_comb begin
      dnx = dv_r[k];
      rx  = DEN_W'(dv_r[k].rem);
      hi  = rx >> QB;
      if (hi >= dv_r[k].den) begin
        dnx.rem   = NUM_W'(((hi - dv_r[k].den) << QB)
                  | (rx & ((DEN_W'(1) << QB) - DEN_W'(1))));
        dnx.q[QB] = 1'b1;
      end
    end

    if (k < N_W) begin : g_sq
      localparam int SB = N_W - 1 - k;
      logic [TR_W-1:0] trial;

      // trying root + 2^SB: remainder must cover root * 2^(SB+1) + 2^(2*SB)
      always_comb begin
        snx   = dnx;
        trial = (TR_W'(dv_r[k].root) << (SB + 1)) + (TR_W'(1) << (2 * SB));
        if (TR_W'(dv_r[k].srem) >= trial) begin
          snx.srem     = WSUM_W'(TR_W'(dv_r[k].srem) - trial);
          snx.root[SB] = 1'b1;
        end
      end
    end else begin : g_nosq
      assign snx = dnx;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= snx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // m1/m2: magnitude times each normalized component, in two halves
  // ---------------------------------------------------------------------------
  dv_t                    dv_last;
  logic                   m1_vld_r, m2_vld_r;
  logic [2:0][70:0]       m1_pl_r;
  logic [2:0][69:0]       m1_ph_r;
  logic [N_W-1:0]         m1_n_r, m2_n_r;
  logic [2:0]             m1_neg_r, m2_neg_r;
  status_t                m1_st_r, m2_st_r;
  logic [2:0][PROD_W-1:0] m2_prod_r;

  assign dv_last = dv_r[QA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= dv_vld_r[QA_W];
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m1_pl_r[i]   <= 71'(dv_last.q[29:0]) * 71'(dv_last.ws[i]);
        m1_ph_r[i]   <= 70'(dv_last.q[QA_W-1:30]) * 70'(dv_last.ws[i]);
        m2_prod_r[i] <= PROD_W'(m1_pl_r[i]) + (PROD_W'(m1_ph_r[i]) << 30);
      end
      m1_n_r   <= dv_last.root;
      m1_neg_r <= dv_last.neg;
      m1_st_r  <= dv_last.st;
      m2_n_r   <= m1_n_r;
      m2_neg_r <= m1_neg_r;
      m2_st_r  <= m1_st_r;
    end
  end

  // ---------------------------------------------------------------------------
  // per-axis divider by the norm: an overflow stage flags quotients at or
  // beyond 2^48 (always saturating), then one quotient bit per stage
  // ---------------------------------------------------------------------------
  fq_t           fq_r [0:QF_W];
  logic [QF_W:0] fq_vld_r;
  fq_t           fq0_nxt;

  always_comb begin
    fq0_nxt     = '0;
    fq0_nxt.rem = m2_prod_r;
    fq0_nxt.n   = m2_n_r;
    fq0_nxt.neg = m2_neg_r;
    fq0_nxt.st  = m2_st_r;
    for (int i = 0; i < 3; i++) begin
      fq0_nxt.ovf[i] = (m2_prod_r[i] >> QF_W) >= PROD_W'(m2_n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_vld_r <= '0;
    end else if (adv) begin
      fq_vld_r <= {fq_vld_r[QF_W-1:0], m2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fq_r[0] <= fq0_nxt;
    end
  end

  for (genvar j = 0; j < QF_W; j++) begin : g_fdiv
    localparam int FB = QF_W - 1 - j;
    fq_t                    fnx;
    logic [2:0][PROD_W-1:0] fhi;

    always_comb begin
      fnx = fq_r[j];
      for (int i = 0; i < 3; i++) begin
        fhi[i] = fq_r[j].rem[i] >> FB;
        if (fhi[i] >= PROD_W'(fq_r[j].n)) begin
          fnx.rem[i]   = ((fhi[i] - PROD_W'(fq_r[j].n)) << FB)
                       | (fq_r[j].rem[i] & ((PROD_W'(1) << FB) - PROD_W'(1)));
          fnx.q[i][FB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fq_r[j+1] <= fnx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: sign, saturation, zeroing on a nonzero status
  // ---------------------------------------------------------------------------
  fq_t                   fq_last;
  logic                  last_vld_r;
  out_item_t             last_r, last_nxt;
  logic [2:0][ACC_W-1:0] acc;
  logic [ACC_W-1:0]      lim, mag;

  assign fq_last = fq_r[QF_W];

  always_comb begin
    lim = '0;
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      lim = fq_last.neg[i] ? ACC_NEG_LIM : ACC_POS_LIM;
      mag = (fq_last.ovf[i] || fq_last.q[i] > lim) ? lim : fq_last.q[i];
      acc[i] = fq_last.neg[i] ? (~mag + ACC_W'(1)) : mag;
      if (fq_last.st != ST_OK) begin
        acc[i] = '0;
      end
    end
    last_nxt.acc_x         = acc[0];
    last_nxt.acc_y         = acc[1];
    last_nxt.acc_z         = acc[2];
    last_nxt.thrust_status = fq_last.st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r <= 1'b0;
    end else if (adv) begin
      last_vld_r <= fq_vld_r[QF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= last_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // skid entry: catches the last stage when the output stalls, so the
  // pipeline can still take one more step that cycle
  // ---------------------------------------------------------------------------
  out_item_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) begin
        skid_full_r <= 1'b0;
      end
    end else if (last_vld_r && out_stall) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= last_r;
    end
  end

  assign out_valid = skid_full_r || last_vld_r;
  assign out_data  = skid_full_r ? skid_r : last_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `LTA_ASSERT_IMP(a_status_zero_vec, clk, rst_n,
    out_valid && out_data.thrust_status != ST_OK,
    out_data.acc_x == '0 && out_data.acc_y == '0 && out_data.acc_z == '0,
    "nonzero status with nonzero acceleration")
  `LTA_ASSERT_IMP(a_norm_range, clk, rst_n,
    dv_vld_r[QA_W] && dv_last.st == ST_OK,
    dv_last.root[N_W-1:N_W-2] != 2'b00,
    "direction norm below 2^40")
  `LTA_ASSERT_NEXT(a_skid_capture, clk, rst_n,
    last_vld_r && out_stall && !skid_full_r,
    skid_full_r && skid_r == $past(last_r),
    "stalled item not captured by skid entry")

endmodule
